/* hw/rtl/rne_pkg.sv */
// Shared types, constants and digit helper functions for the Roman numeral encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rne_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned SYMBOL_W = 7;
    localparam int unsigned BCD_W    = 16;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned POS_W    = 2;
    localparam int unsigned LEN_W    = 3;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;

    typedef struct packed {
        logic       zero;
        logic [1:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } rne_digits_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rne_fifo_stat_t;

    typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} front_state_t;
    typedef enum logic {B_IDLE, B_EMIT} back_state_t;
    typedef enum logic [1:0] {PH_THOU, PH_HUND, PH_TENS, PH_ONES} phase_t;
    typedef enum logic [1:0] {K_ONE, K_FIVE, K_TEN} sym_kind_t;

    // Number of letters that one decimal digit expands to.
    function automatic logic [LEN_W-1:0] digit_len(input logic [3:0] d);
        logic [LEN_W-1:0] n;
        unique case (d)
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Which letter of a digit's set stands at a given position of its run.
    function automatic sym_kind_t sym_kind(input logic [3:0] d, input logic [POS_W-1:0] p);
        sym_kind_t k;
        if (d == 4'd9) begin
            k = (p == '0) ? K_ONE : K_TEN;
        end else if (d == 4'd4) begin
            k = (p == '0) ? K_ONE : K_FIVE;
        end else if (d >= 4'd5) begin
            k = (p == '0) ? K_FIVE : K_ONE;
        end else begin
            k = K_ONE;
        end
        return k;
    endfunction

    function automatic logic [SYMBOL_W-1:0] letter(input phase_t ph, input sym_kind_t k);
        logic [SYMBOL_W-1:0] c;
        c = CH_NONE;
        unique case (ph)
            PH_THOU: c = CH_M;
            PH_HUND: begin
                unique case (k)
                    K_ONE:   c = CH_C;
                    K_FIVE:  c = CH_D;
                    default: c = CH_M;
                endcase
            end
            PH_TENS: begin
                unique case (k)
                    K_ONE:   c = CH_X;
                    K_FIVE:  c = CH_L;
                    default: c = CH_C;
                endcase
            end
            default: begin
                unique case (k)
                    K_ONE:   c = CH_I;
                    K_FIVE:  c = CH_V;
                    default: c = CH_X;
                endcase
            end
        endcase
        return c;
    endfunction

    // First digit position at or after start whose run is not empty.
    function automatic logic [2:0] next_phase(input logic [3:0] nz, input logic [2:0] start);
        logic       found;
        logic [1:0] ph;
        found = 1'b0;
        ph    = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (nz[i] && (3'(i) >= start)) begin
                found = 1'b1;
                ph    = 2'(i);
            end
        end
        return {found, ph};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rne_front.sv */
// Front end: accepts an item, clamps it to 3999 and converts it to decimal digits
// one bit per cycle. Depends on rne_pkg.
`default_nettype none

module rne_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [rne_pkg::VALUE_W-1:0]  s_value,
    input  wire rne_pkg::rne_fifo_stat_t      fifo_stat,
    output logic                              push,
    output rne_pkg::rne_digits_t              push_data
);
    import rne_pkg::*;

    front_state_t         state_reg, state_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 zero_reg, zero_next;
    logic [BCD_W-1:0]     adj;
    logic [VALUE_W-1:0]   sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        val_reg  <= val_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        for (int i = 0; i < BCD_W / 4; i++) begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                        : bcd_reg[i*4 +: 4];
        end
    end

    assign sat = (s_value > MAX_VALUE) ? MAX_VALUE : s_value;

    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        push_data  = '{zero: zero_reg, thou: bcd_reg[13:12], hund: bcd_reg[11:8],
                       tens: bcd_reg[7:4], ones: bcd_reg[3:0]};
        unique case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    val_next   = sat;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_W - 1);
                    zero_next  = (sat == '0);
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                bcd_next = {adj[BCD_W-2:0], val_reg[VALUE_W-1]};
                val_next = {val_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = F_PUSH;
                end
            end
            default: begin
                if (!fifo_stat.full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/rne_fifo.sv */
// Two-entry queue of decoded digit sets between the front and back ends.
// Depends on rne_pkg.
`default_nettype none

module rne_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire rne_pkg::rne_digits_t  push_data,
    input  wire logic                  pop,
    output rne_pkg::rne_digits_t       pop_data,
    output rne_pkg::rne_fifo_stat_t    stat
);
    import rne_pkg::*;

    rne_digits_t mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rne_back.sv */
// Back end: takes digit sets from the queue and emits one numeral letter per cycle
// into an output register while m_ready does not stall it. Depends on rne_pkg.
`default_nettype none

module rne_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rne_pkg::rne_fifo_stat_t       fifo_stat,
    input  wire rne_pkg::rne_digits_t          pop_data,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rne_pkg::SYMBOL_W-1:0]       m_symbol,
    output logic                               m_last,
    output logic                               m_empty_res
);
    import rne_pkg::*;

    back_state_t          state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    rne_digits_t          dig_reg, dig_next;
    logic                 valid_reg, valid_next;
    logic [SYMBOL_W-1:0]  symbol_reg, symbol_next;
    logic                 last_reg, last_next;
    logic                 empty_reg, empty_next;

    logic                 load_ok;
    logic [3:0]           cur_digit;
    logic [3:0]           nz_cur, nz_new;
    logic [2:0]           np_cur, np_new;
    logic [LEN_W-1:0]     cur_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        phase_reg  <= phase_next;
        pos_reg    <= pos_next;
        dig_reg    <= dig_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
    end

    assign load_ok = !valid_reg || m_ready;

    always_comb begin
        unique case (phase_reg)
            PH_THOU: cur_digit = {2'b00, dig_reg.thou};
            PH_HUND: cur_digit = dig_reg.hund;
            PH_TENS: cur_digit = dig_reg.tens;
            default: cur_digit = dig_reg.ones;
        endcase
    end

    assign cur_len = digit_len(cur_digit);
    assign nz_cur  = {digit_len(dig_reg.ones) != '0, digit_len(dig_reg.tens) != '0,
                      digit_len(dig_reg.hund) != '0, dig_reg.thou != '0};
    assign nz_new  = {digit_len(pop_data.ones) != '0, digit_len(pop_data.tens) != '0,
                      digit_len(pop_data.hund) != '0, pop_data.thou != '0};
    assign np_cur  = next_phase(nz_cur, {1'b0, phase_reg} + 3'd1);
    assign np_new  = next_phase(nz_new, 3'd0);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        dig_next    = dig_reg;
        valid_next  = valid_reg && !m_ready;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        empty_next  = empty_reg;
        pop         = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!fifo_stat.empty && load_ok) begin
                    pop = 1'b1;
                    if (pop_data.zero) begin
                        valid_next  = 1'b1;
                        symbol_next = CH_NONE;
                        last_next   = 1'b1;
                        empty_next  = 1'b1;
                    end else begin
                        dig_next   = pop_data;
                        phase_next = phase_t'(np_new[1:0]);
                        pos_next   = '0;
                        state_next = B_EMIT;
                    end
                end
            end
            default: begin
                if (load_ok) begin
                    valid_next  = 1'b1;
                    symbol_next = letter(phase_reg, sym_kind(cur_digit, pos_reg));
                    empty_next  = 1'b0;
                    last_next   = 1'b0;
                    if ({1'b0, pos_reg} + 3'd1 < cur_len) begin
                        pos_next = pos_reg + 1'b1;
                    end else if (np_cur[2]) begin
                        phase_next = phase_t'(np_cur[1:0]);
                        pos_next   = '0;
                    end else begin
                        last_next  = 1'b1;
                        state_next = B_IDLE;
                    end
                end
            end
        endcase
    end

    assign m_valid     = valid_reg;
    assign m_symbol    = symbol_reg;
    assign m_last      = last_reg;
    assign m_empty_res = empty_reg;

endmodule

`default_nettype wire

/* hw/rtl/roman_numeral_encoder_top.sv */
// Top level of the Roman numeral encoder: front end, digit queue and back end.
// Depends on rne_pkg, rne_front, rne_fifo and rne_back.
`default_nettype none

// Each item is a value that is written as a Roman numeral, one ASCII letter per
// result, most significant letter first, with m_last on the final letter. Values
// above 3999 are clamped to 3999, and a value of zero gives one result with symbol
// 0 and both m_last and m_empty_res set. The front end converts the value to
// decimal one bit per cycle and takes no new item until it has pushed the digit
// set into the queue. The back end fetches each digit set from a two-entry queue
// and then emits one letter per cycle while m_ready does not stall the output.
module roman_numeral_encoder_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [rne_pkg::VALUE_W-1:0]  s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rne_pkg::SYMBOL_W-1:0]      m_symbol,
    output logic                              m_last,
    output logic                              m_empty_res
);
    import rne_pkg::*;

    rne_fifo_stat_t fifo_stat;
    rne_digits_t    push_data;
    rne_digits_t    pop_data;
    logic           push;
    logic           pop;

    rne_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    rne_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    rne_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_stat   (fifo_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last),
        .m_empty_res (m_empty_res)
    );

    a_empty_is_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last && (m_symbol == CH_NONE))
        else $error("empty result is not a lone terminated item");

    a_letter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res |-> (m_symbol != CH_NONE))
        else $error("numeral letter is missing");

    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue reports full and empty together");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_stat.full)
        else $error("push into a full queue");

    a_front_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front end accepted an item while converting");

endmodule

`default_nettype wire

/* tb/roman_numeral_encoder_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for roman_numeral_encoder_top: drives values with random bursts
// and output stalls, predicts every letter of each numeral and compares them in order.
// Depends on rne_pkg and the encoder RTL.

module roman_numeral_encoder_top_test;
    import rne_pkg::*;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                empty_res;
    } letter_t;

    typedef enum logic [1:0] {RDY_FREE, RDY_COIN, RDY_SPARSE, RDY_HOLD} ready_mode_t;

    localparam int RANDOM_ITEMS = 185;
    localparam int TAIL_CYCLES  = 40;

    class numeral_scoreboard;
        letter_t     pending_letters[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function void push_letter(logic [SYMBOL_W-1:0] c);
            pending_letters.push_back('{c, 1'b0, 1'b0});
        endfunction

        function void push_digit(int d, logic [SYMBOL_W-1:0] one, logic [SYMBOL_W-1:0] five,
                                 logic [SYMBOL_W-1:0] ten);
            if (d == 9) begin
                push_letter(one);
                push_letter(ten);
            end else if (d >= 5) begin
                push_letter(five);
                for (int j = 5; j < d; j++) push_letter(one);
            end else if (d == 4) begin
                push_letter(one);
                push_letter(five);
            end else begin
                for (int j = 0; j < d; j++) push_letter(one);
            end
        endfunction

        // Values above the legal range are encoded as the largest legal value.
        function void note_value(logic [VALUE_W-1:0] raw);
            int v;
            v = (raw > MAX_VALUE) ? int'(MAX_VALUE) : int'(raw);
            if (v == 0) begin
                pending_letters.push_back('{CH_NONE, 1'b1, 1'b1});
            end else begin
                for (int j = 0; j < v / 1000; j++) push_letter(CH_M);
                push_digit((v / 100) % 10, CH_C, CH_D, CH_M);
                push_digit((v / 10) % 10, CH_X, CH_L, CH_C);
                push_digit(v % 10, CH_I, CH_V, CH_X);
                pending_letters[pending_letters.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string field, logic [SYMBOL_W-1:0] got, logic [SYMBOL_W-1:0] want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
            errors++;
        endtask

        task check_letter(logic [SYMBOL_W-1:0] symbol, logic last, logic empty_res);
            letter_t want;
            if (pending_letters.size() == 0) begin
                report("unexpected item", symbol, '0);
            end else begin
                want = pending_letters.pop_front();
                if (symbol !== want.symbol) report("symbol", symbol, want.symbol);
                if (last !== want.last) report("last", last, want.last);
                if (empty_res !== want.empty_res) report("empty_res", empty_res, want.empty_res);
            end
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SYMBOL_W-1:0] m_symbol;
    logic                m_last;
    logic                m_empty_res;

    ready_mode_t ready_mode = RDY_FREE;
    int          ready_hold = 0;

    numeral_scoreboard sb = new();

    int directed_values[25] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 3999, 4000, 4095, 3888, 1000,
                                2000, 3000, 400, 900, 40, 90, 444, 999, 1994, 2048};

    roman_numeral_encoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last),
        .m_empty_res (m_empty_res)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(1, 40);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            RDY_FREE:   m_ready <= 1'b1;
            RDY_COIN:   m_ready <= $urandom_range(0, 1);
            RDY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:    m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_value(s_value);
        if (aresetn && m_valid && m_ready) sb.check_letter(m_symbol, m_last, m_empty_res);
    end

    task send_value(logic [VALUE_W-1:0] v);
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task pause_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_letters.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return VALUE_W'($urandom_range(4000, 4095));
            1:       return '0;
            2, 3:    return VALUE_W'($urandom_range(0, 15));
            4:       return VALUE_W'($urandom);
            default: return VALUE_W'($urandom_range(0, 3999));
        endcase
    endfunction

    initial begin
        int burst_left;
        burst_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_values[i]) begin
            send_value(VALUE_W'(directed_values[i]));
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 6));
        end
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                wait_for_drain();
            end else if (burst_left == 0) begin
                pause_sender($urandom_range(1, 20));
                burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            end
            send_value(random_value());
            if (burst_left > 0) burst_left--;
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
